### hw/rtl/dhf_pkg.sv
// shared types, constants and character helpers for the hex float text converter
package dhf_pkg;

  localparam int FRAC_W = 52;
  localparam int FRAC_DIGITS = 13;
  localparam int EXP_W = 12;
  localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
  localparam logic signed [EXP_W-1:0] EXP_BIAS = 12'sd1023;
  localparam logic signed [EXP_W-1:0] EXP_MIN = -12'sd1022;
  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LP = 8'h70;
  localparam logic [7:0] CH_UP = 8'h50;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_ROUND,
    ST_EMIT
  } dhf_state_t;

  typedef enum logic [2:0] {
    PH_ZERO,
    PH_X,
    PH_LEAD,
    PH_POINT,
    PH_DIGIT,
    PH_P,
    PH_SIGN,
    PH_EXP
  } dhf_phase_t;

  typedef struct packed {
    logic       load;
    logic       norm;
    logic       round;
    logic       emit;
    logic       shift;
    logic       last;
    dhf_phase_t phase;
    logic [1:0] exp_sel;
  } dhf_cmd_t;

  typedef struct packed {
    logic       norm_done;
    logic [3:0] ndig;
    logic       point;
    logic [1:0] exp_top;
    logic       out_free;
  } dhf_status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic up);
    logic [7:0] base;
    base = up ? CH_UA : CH_LA;
    if (d > 4'd9) begin
      return base + 8'(d - 4'd10);
    end
    return CH_ZERO + {4'b0000, d};
  endfunction

endpackage

### hw/rtl/dhf_ctrl.sv
// sequencer for one conversion: normalize, round, then one character per output slot
module dhf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dhf_pkg::dhf_status_t st,
  output dhf_pkg::dhf_cmd_t    cmd
);
  import dhf_pkg::*;

  dhf_state_t state, state_next;
  dhf_phase_t phase, phase_next;
  logic [3:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_ZERO;
      cnt   <= 4'd0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (st.norm_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_EMIT;
        phase_next = PH_ZERO;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          unique case (phase)
            PH_ZERO: phase_next = PH_X;
            PH_X:    phase_next = PH_LEAD;
            PH_LEAD: phase_next = st.point ? PH_POINT : PH_P;
            PH_POINT: begin
              if (st.ndig != 4'd0) begin
                phase_next = PH_DIGIT;
                cnt_next   = st.ndig - 4'd1;
              end else begin
                phase_next = PH_P;
              end
            end
            PH_DIGIT: begin
              if (cnt == 4'd0) begin
                phase_next = PH_P;
              end else begin
                cnt_next = cnt - 4'd1;
              end
            end
            PH_P:    phase_next = PH_SIGN;
            PH_SIGN: begin
              phase_next = PH_EXP;
              cnt_next   = {2'b00, st.exp_top};
            end
            PH_EXP: begin
              if (cnt == 4'd0) begin
                state_next = ST_IDLE;
              end else begin
                cnt_next = cnt - 4'd1;
              end
            end
            default: phase_next = PH_ZERO;
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd         = '0;
    cmd.phase   = phase;
    cmd.exp_sel = cnt[1:0];
    cmd.load    = (state == ST_IDLE) && in_valid;
    cmd.norm    = (state == ST_NORM) && !st.norm_done;
    cmd.round   = (state == ST_ROUND);
    cmd.emit    = (state == ST_EMIT) && st.out_free;
    cmd.shift   = cmd.emit && (phase == PH_DIGIT);
    cmd.last    = (phase == PH_EXP) && (cnt == 4'd0);
  end

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && phase == PH_DIGIT) |-> (st.ndig != 4'd0 && cnt < st.ndig))
    else $error("fraction digit counter out of range");

  a_exp_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && phase == PH_EXP) |-> (cnt <= {2'b00, st.exp_top}))
    else $error("exponent digit counter beyond leading digit");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> in_ready)
    else $error("not ready for a new item after the final character");

endmodule

### hw/rtl/dhf_datapath.sv
// operand registers, normalizer, rounder, exponent digit pipeline and output register
module dhf_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [63:0]          value_bits,
  input  logic signed [4:0]    precision,
  input  logic                 alternate_flag,
  input  logic                 upper_case,
  input  dhf_pkg::dhf_cmd_t    cmd,
  output dhf_pkg::dhf_status_t st,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_char,
  output logic                 out_neg,
  output logic                 out_last
);
  import dhf_pkg::*;

  // working operand: bit 52 is the leading one once normalized
  logic [FRAC_W:0]          m;
  logic signed [EXP_W-1:0]  e;
  logic                     lead;
  logic                     neg;
  logic                     up;
  logic                     alt;
  logic [4:0]               prec;
  logic [3:0]               ndig;
  logic                     point;

  logic [10:0]              in_bexp;
  logic [FRAC_W-1:0]        in_frac;

  logic [FRAC_W-1:0]        frac;
  logic [3:0]               nd_given;
  logic [3:0]               nd_trim;
  logic [5:0]               sh;
  logic [FRAC_W-1:0]        dropmask;
  logic [FRAC_W-1:0]        lowmask;
  logic                     guard;
  logic                     lsb;
  logic                     sticky;
  logic                     rnd_up;
  logic [FRAC_W:0]          sum;
  logic                     carry;
  logic [FRAC_W-1:0]        frac_new;
  logic [3:0]               nd_new;
  logic                     carry_new;

  // exponent digit pipeline
  logic [10:0]              e_abs;
  logic                     s1_neg, s2_neg, s3_neg;
  logic                     s1_th, s2_th;
  logic [9:0]               s1_r;
  logic [15:0]              hu_prod;
  logic [3:0]               hu_q;
  logic [9:0]               r2_full;
  logic [3:0]               s2_hu;
  logic [6:0]               s2_r;
  logic [14:0]              te_prod;
  logic [3:0]               te_q;
  logic [6:0]               on_full;
  logic [3:0]               d3, d2, d1, d0;
  logic [1:0]               exp_top;

  logic [3:0]               sel_digit;
  logic [7:0]               ch;

  assign in_bexp = value_bits[62:52];
  assign in_frac = value_bits[FRAC_W-1:0];
  assign frac    = m[FRAC_W-1:0];

  // trailing zero trim: lowest nonzero nibble sets the digit count
  always_comb begin
    nd_trim = 4'd0;
    for (int i = FRAC_DIGITS - 1; i >= 0; i--) begin
      if ((frac[4*i +: 4] & NIBBLE_MASK) != 4'd0) begin
        nd_trim = 4'(FRAC_DIGITS - i);
      end
    end
  end

  // round to nearest, ties to even, at the chosen nibble boundary; negative prec trims instead
  always_comb begin
    nd_given = (prec[3:0] > 4'(FRAC_DIGITS)) ? 4'(FRAC_DIGITS) : prec[3:0];
    sh       = {4'(FRAC_DIGITS) - nd_given, 2'b00};
    for (int b = 0; b < FRAC_W; b++) begin
      dropmask[b] = (6'(b) < sh);
      lowmask[b]  = (6'(b + 1) < sh);
    end
    guard  = (sh != 6'd0) ? m[sh - 6'd1] : 1'b0;
    lsb    = m[sh];
    sticky = |(frac & lowmask);
    rnd_up = guard && (sticky || lsb);
    sum    = {1'b0, frac & ~dropmask} + ((FRAC_W+1)'(rnd_up) << sh);
    carry  = sum[FRAC_W];
    if (prec[4]) begin
      frac_new  = frac;
      nd_new    = nd_trim;
      carry_new = 1'b0;
    end else begin
      frac_new  = carry ? '0 : sum[FRAC_W-1:0];
      nd_new    = nd_given;
      carry_new = carry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m    <= {in_bexp != 11'd0, in_frac};
      lead <= (in_bexp != 11'd0) || (in_frac != '0);
      neg  <= value_bits[63];
      up   <= upper_case;
      alt  <= alternate_flag;
      prec <= precision;
      if (in_bexp == 11'd0) begin
        e <= (in_frac == '0) ? '0 : EXP_MIN;
      end else begin
        e <= $signed({1'b0, in_bexp}) - EXP_BIAS;
      end
    end else if (cmd.norm) begin
      if (m[FRAC_W -: 8] == 8'd0) begin
        m <= {m[FRAC_W-8:0], 8'd0};
        e <= e - 12'sd8;
      end else begin
        m <= {m[FRAC_W-1:0], 1'b0};
        e <= e - 12'sd1;
      end
    end else if (cmd.round) begin
      m[FRAC_W-1:0] <= frac_new;
      e             <= e + $signed({11'd0, carry_new});
      ndig          <= nd_new;
      point         <= (nd_new != 4'd0) || alt;
    end else if (cmd.shift) begin
      m[FRAC_W-1:0] <= {m[FRAC_W-5:0], 4'd0};
    end
  end

  // exponent to decimal digits, registered through the s1, s2 and digit (d3 to d0) stages
  assign e_abs   = e[EXP_W-1] ? 11'(-e) : e[10:0];
  assign hu_prod = {6'd0, s1_r} * 16'd41;
  assign hu_q    = hu_prod[15:12];
  assign r2_full = s1_r - (10'(hu_q) * 10'd100);
  assign te_prod = {8'd0, s2_r} * 15'd205;
  assign te_q    = te_prod[14:11];
  assign on_full = s2_r - (7'(te_q) * 7'd10);

  always_ff @(posedge clk) begin
    s1_neg <= e[EXP_W-1];
    s1_th  <= (e_abs >= 11'd1000);
    s1_r   <= (e_abs >= 11'd1000) ? 10'(e_abs - 11'd1000) : e_abs[9:0];
    s2_neg <= s1_neg;
    s2_th  <= s1_th;
    s2_hu  <= hu_q;
    s2_r   <= r2_full[6:0];
    s3_neg <= s2_neg;
    d3     <= {3'd0, s2_th};
    d2     <= s2_hu;
    d1     <= te_q;
    d0     <= on_full[3:0];
    if (s2_th) begin
      exp_top <= 2'd3;
    end else if (s2_hu != 4'd0) begin
      exp_top <= 2'd2;
    end else if (te_q != 4'd0) begin
      exp_top <= 2'd1;
    end else begin
      exp_top <= 2'd0;
    end
  end

  always_comb begin
    unique case (cmd.exp_sel)
      2'd3:    sel_digit = d3;
      2'd2:    sel_digit = d2;
      2'd1:    sel_digit = d1;
      default: sel_digit = d0;
    endcase
  end

  always_comb begin
    unique case (cmd.phase)
      PH_ZERO:  ch = CH_ZERO;
      PH_X:     ch = up ? CH_UX : CH_LX;
      PH_LEAD:  ch = CH_ZERO + {7'd0, lead};
      PH_POINT: ch = CH_POINT;
      PH_DIGIT: ch = hex_char(m[FRAC_W-1 -: 4], up);
      PH_P:     ch = up ? CH_UP : CH_LP;
      PH_SIGN:  ch = s3_neg ? CH_MINUS : CH_PLUS;
      PH_EXP:   ch = CH_ZERO + {4'd0, sel_digit};
      default:  ch = CH_ZERO;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= ch;
      out_neg  <= neg;
      out_last <= cmd.last;
    end
  end

  always_comb begin
    st.norm_done = m[FRAC_W] || !lead;
    st.ndig      = ndig;
    st.point     = point;
    st.exp_top   = exp_top;
    st.out_free  = !out_valid || out_ready;
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("character written over one not yet taken");

  a_norm_lead: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> (m[FRAC_W] == lead))
    else $error("rounding started on an operand that is not normalized");

  a_exp_digit: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.phase == PH_EXP) |-> (sel_digit <= 4'd9))
    else $error("exponent digit out of decimal range");

endmodule

### hw/rtl/double_to_hex_float_text_core.sv
// top level of the double to hex float text converter
//
// usage: one item on the slave side carries a raw double and its format
// controls; the master side returns the text one ascii character per item,
// "0x", leading digit, optional point, fraction digits, "p", exponent sign
// and decimal exponent. tuser carries the sign bit of the value on every
// character, tlast marks the final character of a conversion.
// start: after an input item is accepted the sequencer shifts subnormal
// operands up to normal form (8 bits or 1 bit per step), rounds, and then
// writes the first character. the characters then follow one per cycle
// while m_tready is high, 6 to 23 of them, through the single output
// register. flow: one conversion at a time; a new item is taken in the
// cycle after the final character enters the output register.
// stalls: with m_tready low the output register holds its character and
// the sequencer waits; nothing is dropped.
// reset: rst (synchronous) empties the output register and returns the
// sequencer to idle, ready for an item.
module double_to_hex_float_text_core (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        s_tvalid,
  output logic        s_tready,
  // [63:0] value_bits, [68:64] precision, [69] alternate_flag,
  // [70] upper_case, [71] zero
  input  logic [71:0] s_tdata,
  // character channel
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] out_char
  output logic [7:0]  m_tdata,
  // [0] negative
  output logic        m_tuser,
  output logic        m_tlast
);
  import dhf_pkg::*;

  dhf_cmd_t    cmd;
  dhf_status_t st;

  // controller: idle, normalize, round, then emit through the text phases
  dhf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: operand, rounder, exponent digits and the output register
  dhf_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .value_bits     (s_tdata[63:0]),
    .precision      ($signed(s_tdata[68:64])),
    .alternate_flag (s_tdata[69]),
    .upper_case     (s_tdata[70]),
    .cmd            (cmd),
    .st             (st),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_char       (m_tdata),
    .out_neg        (m_tuser),
    .out_last       (m_tlast)
  );

endmodule

### tb/tb.sv
// self-checking testbench for the double to hex float text converter
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dhf_pkg::*;

  // precision code for "none given": any negative value, -1 is the usual one
  localparam logic [4:0] PREC_NONE = 5'h1f;
  localparam logic [4:0] PREC_MOST_NEG = 5'h10;
  localparam int N_DIRECTED = 23;
  localparam int RANDOM_PER_PHASE = 29;
  // cycles with no item moving on either side before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  // one conversion request as it travels on the slave side
  typedef struct packed {
    logic [63:0] bits;
    logic [4:0]  prec;
    logic        alt;
    logic        up;
  } conv_req_t;

  // one expected character item on the master side
  typedef struct packed {
    logic [7:0] ch;
    logic       neg;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [63:0] value_bits, [68:64] precision, [69] alternate_flag,
  // [70] upper_case, [71] zero
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [7:0] out_char
  logic [7:0]  m_tdata;
  // [0] negative
  logic        m_tuser;
  logic        m_tlast;

  text_char_t pending_chars[$];
  text_char_t want;
  int         fail_count = 0;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         quiet_cycles = 0;

  double_to_hex_float_text_core dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // directed table: zeros of both signs, extremes of the exponent range,
  // subnormals, infinity and nan patterns, rounding ties and carries,
  // negative and oversized precision, both letter cases, the forced point
  conv_req_t dir_req[N_DIRECTED] = '{
    '{64'h0000000000000000, PREC_NONE,     1'b0, 1'b0},
    '{64'h8000000000000000, PREC_NONE,     1'b0, 1'b1},
    '{64'h0000000000000000, 5'd3,          1'b0, 1'b0},
    '{64'h8000000000000000, 5'd0,          1'b1, 1'b0},
    '{64'h3ff0000000000000, PREC_NONE,     1'b0, 1'b0},
    '{64'h3ff0000000000000, PREC_NONE,     1'b1, 1'b0},
    '{64'h3ff0000000000000, 5'd15,         1'b0, 1'b1},
    '{64'h7fefffffffffffff, PREC_NONE,     1'b0, 1'b0},
    '{64'h7fefffffffffffff, 5'd0,          1'b0, 1'b0},
    '{64'h0000000000000001, PREC_NONE,     1'b0, 1'b0},
    '{64'h000fffffffffffff, 5'd14,         1'b0, 1'b1},
    '{64'h0010000000000000, PREC_NONE,     1'b0, 1'b0},
    '{64'hfff0000000000000, PREC_NONE,     1'b0, 1'b1},
    '{64'h7fffffffffffffff, 5'd12,         1'b0, 1'b0},
    '{64'h3ff0000000000008, 5'd12,         1'b0, 1'b0},
    '{64'h3ff0000000000018, 5'd12,         1'b0, 1'b0},
    '{64'h3ff8000000000000, 5'd0,          1'b0, 1'b0},
    '{64'hbff7ffffffffffff, 5'd0,          1'b1, 1'b0},
    '{64'h3ff8000000000000, PREC_MOST_NEG, 1'b0, 1'b0},
    '{64'hffffffffffffffff, 5'd13,         1'b1, 1'b1},
    '{64'h3fb999999999999a, 5'd1,          1'b0, 1'b0},
    '{64'h3ffabcdef0123456, PREC_NONE,     1'b0, 1'b1},
    '{64'h0000000000000001, 5'd13,         1'b0, 1'b0}
  };

  // text typed in where it is obvious, empty means ask the predictor
  string dir_text[N_DIRECTED] = '{
    "0x0p+0",
    "0X0P+0",
    "0x0.000p+0",
    "0x0.p+0",
    "0x1p+0",
    "0x1.p+0",
    "0X1.0000000000000P+0",
    "0x1.fffffffffffffp+1023",
    "",
    "0x1p-1074",
    "",
    "0x1p-1022",
    "0X1P+1024",
    "",
    "",
    "",
    "",
    "",
    "0x1.8p+0",
    "",
    "",
    "",
    "0x1.0000000000000p-1074"
  };

  // works out the %a text of one request and queues its characters
  function automatic void format_hex_text(input conv_req_t r);
    logic [7:0]  chars[$];
    logic [7:0]  dec[$];
    logic [63:0] frac, rem, half;
    logic [10:0] bexp;
    logic [3:0]  nib;
    int          lead, expo, ndig, sh, mag;
    bit          round_bit, carry;

    bexp = r.bits[62:52];
    frac = {12'b0, r.bits[51:0]};
    if (bexp == '0 && frac == '0) begin
      lead = 0;
      expo = 0;
    end else if (bexp == '0) begin
      // subnormal: shift the top set bit up to the hidden bit position
      lead = 1;
      expo = -1022;
      while (frac[52] == 1'b0) begin
        frac = frac << 1;
        expo--;
      end
      frac[52] = 1'b0;
    end else begin
      lead = 1;
      expo = bexp;
      expo = expo - 1023;
    end

    if (r.prec[4]) begin
      // no precision: drop trailing zero nibbles
      ndig = 13;
      while (ndig > 0 && frac[3:0] == 4'h0) begin
        frac = frac >> 4;
        ndig--;
      end
    end else begin
      ndig = (r.prec > 5'd13) ? 13 : int'(r.prec);
      sh = 4 * (13 - ndig);
      if (sh > 0) begin
        rem = frac & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        frac = frac >> sh;
        // ties go to even, judged on the leading digit when no fraction is left
        round_bit = (ndig == 0) ? (lead == 1) : frac[0];
        if (rem > half || (rem == half && round_bit)) frac = frac + 64'd1;
        carry = (ndig == 0) ? (frac != '0) : ((frac >> (4 * ndig)) != '0);
        if (carry) begin
          frac = '0;
          lead++;
          if (lead == 2) begin
            lead = 1;
            expo++;
          end
        end
      end
    end

    chars.push_back(CH_ZERO);
    chars.push_back(r.up ? CH_UX : CH_LX);
    chars.push_back(8'(CH_ZERO + lead));
    if (ndig > 0 || r.alt) chars.push_back(CH_POINT);
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = frac[4*i +: 4];
      if (nib > 4'd9) chars.push_back(8'((r.up ? CH_UA : CH_LA) + nib - 4'd10));
      else chars.push_back(8'(CH_ZERO + nib));
    end
    chars.push_back(r.up ? CH_UP : CH_LP);
    chars.push_back((expo < 0) ? CH_MINUS : CH_PLUS);
    mag = (expo < 0) ? -expo : expo;
    do begin
      dec.push_front(8'(CH_ZERO + mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (dec[i]) chars.push_back(dec[i]);

    foreach (chars[i])
      pending_chars.push_back('{ch: chars[i], neg: r.bits[63], last: (i == chars.size() - 1)});
  endfunction

  // random request, partly aimed at rounding boundaries and odd exponents
  function automatic conv_req_t random_request();
    conv_req_t   r;
    logic [51:0] mant;
    logic [10:0] bexp;
    logic [63:0] mask, half, low;
    int          nd;

    mant = 52'({$urandom, $urandom});
    bexp = 11'($urandom_range(2047));
    r.alt = 1'($urandom_range(1));
    r.up = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: r.prec = PREC_NONE;
      1: r.prec = 5'($urandom_range(13));
      2: r.prec = 5'($urandom_range(31));
      default: r.prec = 5'($urandom_range(3));
    endcase
    case ($urandom_range(7))
      0: r.bits = {$urandom, $urandom};
      1: r.bits = {1'($urandom_range(1)), 11'($urandom_range(1, 2046)), mant};
      2: r.bits = {1'($urandom_range(1)), 11'h000, mant >> $urandom_range(51)};
      3: begin
        // zeros, infinities and nan patterns
        bexp = $urandom_range(1) ? 11'h7ff : 11'h000;
        if ($urandom_range(1)) mant = '0;
        r.bits = {1'($urandom_range(1)), bexp, mant};
      end
      4: begin
        // few significant nibbles so trimming has work to do
        mask = (64'd1 << (4 * $urandom_range(13))) - 64'd1;
        r.bits = {1'($urandom_range(1)), bexp, mant & ~mask[51:0]};
      end
      7: begin
        case ($urandom_range(3))
          0: bexp = 11'h7fe;
          1: bexp = 11'h001;
          2: bexp = 11'h000;
          default: bexp = 11'h7ff;
        endcase
        if ($urandom_range(1)) mant = '1;
        r.bits = {1'($urandom_range(1)), bexp, mant};
      end
      default: begin
        // cut point sits right on, just under or just over a half, or all ones or all zeros below it
        nd = $urandom_range(12);
        mask = (64'd1 << (4 * (13 - nd))) - 64'd1;
        half = (mask >> 1) + 64'd1;
        case ($urandom_range(4))
          0: low = half;
          1: low = half - 64'd1;
          2: low = half + 64'd1;
          3: low = mask;
          default: low = '0;
        endcase
        r.bits = {1'($urandom_range(1)), bexp, (mant & ~mask[51:0]) | low[51:0]};
        r.prec = 5'(nd);
      end
    endcase
    return r;
  endfunction

  // offers one request, waits for the handshake, then queues what it should print
  task automatic send_request(input conv_req_t r, input string typed);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, r.up, r.alt, r.prec, r.bits};
    do @(posedge clk); while (!s_tready);
    if (typed.len() == 0) begin
      format_hex_text(r);
    end else begin
      for (int i = 0; i < typed.len(); i++)
        pending_chars.push_back('{ch: typed[i], neg: r.bits[63], last: (i == typed.len() - 1)});
    end
  endtask

  // character side: check each accepted item against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected char item: ch=%h neg=%b last=%b", m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (m_tdata !== want.ch || m_tuser !== want.neg || m_tlast !== want.last) begin
          if (fail_count < 10)
            $display("char mismatch: expected ch=%h neg=%b last=%b, got ch=%h neg=%b last=%b",
                     want.ch, want.neg, want.last, m_tdata, m_tuser, m_tlast);
          fail_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles where nothing moves on either side
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[double_to_hex_float_text_core] ERROR");
    $finish;
  end

  int send_idle_by_phase[3] = '{20, 64, 0};
  int recv_idle_by_phase[3] = '{64, 20, 0};

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = send_idle_by_phase[ph];
      recv_idle = recv_idle_by_phase[ph];
      if (ph == 0) begin
        for (int i = 0; i < N_DIRECTED; i++) send_request(dir_req[i], dir_text[i]);
      end
      repeat (RANDOM_PER_PHASE) send_request(random_request(), "");
    end
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    // catch any stray characters after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    fail_count += pending_chars.size();
    if (fail_count == 0) begin
      $display("[double_to_hex_float_text_core] OK");
    end else begin
      $display("[double_to_hex_float_text_core] ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dhf_pkg.sv
hw/rtl/dhf_ctrl.sv
hw/rtl/dhf_datapath.sv
hw/rtl/double_to_hex_float_text_core.sv
tb/tb.sv
